@@ rtl/sedd_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers for the serpentine dither
// no dependencies

package sedd_pkg;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int PIX_W        = 8;
    localparam int ERR_W        = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // diffusion weights in sixteenths
    localparam logic [3:0] K_AHEAD  = 4'd1;
    localparam logic [3:0] K_ABOVE  = 4'd5;
    localparam logic [3:0] K_BEHIND = 4'd3;
    localparam logic [3:0] K_PRED   = 4'd7;

    localparam logic [PIX_W-1:0] THRESH  = 8'd127;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic above;      // a row above exists
        logic behind;     // not the first pixel of the row
        logic has_ahead;  // a pixel follows in this row
        logic row_last;
        logic frame_last;
    } t_flags;

    // err * k / 16, rounded half away from zero
    function automatic logic signed [ERR_W-1:0] diffuse(input logic signed [ERR_W-1:0] err,
                                                        input logic [3:0] k);
        logic signed [12:0] n;
        logic [12:0]        mag;
        logic [12:0]        q;
        logic [7:0]         q8;
        n   = 13'(err) * $signed({9'd0, k});
        mag = n[12] ? 13'(-n) : 13'(n);
        q   = (mag + 13'd8) >> 4;
        q8  = q[7:0];
        return n[12] ? $signed(8'(-q8)) : $signed(q8);
    endfunction

    // add a signed term to a pixel and clamp to 0..255
    function automatic logic [PIX_W-1:0] clamp_add(input logic [PIX_W-1:0] v,
                                                  input logic signed [ERR_W-1:0] t);
        logic signed [9:0] s;
        s = $signed({2'b00, v}) + 10'(t);
        if (s < 10'sd0) begin
            return '0;
        end else if (s > 10'sd255) begin
            return PIX_MAX;
        end else begin
            return s[7:0];
        end
    endfunction

endpackage

@@ rtl/sedd_front.sv @@
`timescale 1ns / 1ps
// front end: configuration registers, serpentine column/row counters,
// per-pixel classification into store addresses and edge flags; uses sedd_pkg

module sedd_front
    import sedd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_queue_full,
    output logic                  o_ready,
    output logic                  o_push,
    output logic [PIX_W-1:0]      o_pixel,
    output logic [AW-1:0]         o_col,
    output logic [AW-1:0]         o_ahead,
    output t_flags                o_flags
);

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [AW-1:0]           r_col_cnt;
    logic [RW-1:0]           r_row_cnt;

    logic [AW-1:0] w_last_col;
    logic [RW-1:0] w_last_row;
    logic [AW-1:0] w_cnt;
    logic [RW-1:0] w_row;
    logic [AW-1:0] w_col;
    logic          w_rtl;
    logic          w_row_last;
    logic          w_frame_last;
    logic          w_accept;

    // out-of-range sizes act as the nearest legal size
    always_comb begin
        if (r_width == '0) begin
            w_last_col = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_last_col = AW'(MAX_WIDTH - 1);
        end else begin
            w_last_col = AW'(r_width - 1'b1);
        end
        if (r_height == '0) begin
            w_last_row = '0;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            w_last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            w_last_row = RW'(r_height - 1'b1);
        end
    end

    // counters saturate if the size shrank in mid-frame
    assign w_cnt        = (r_col_cnt > w_last_col) ? w_last_col : r_col_cnt;
    assign w_row        = (r_row_cnt > w_last_row) ? w_last_row : r_row_cnt;
    assign w_rtl        = ~w_row[0];
    assign w_col        = w_rtl ? (w_last_col - w_cnt) : w_cnt;
    assign w_row_last   = (w_cnt == w_last_col);
    assign w_frame_last = w_row_last && (w_row == w_last_row);

    assign o_ready  = ~i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept;
    assign o_pixel  = i_pixel;
    assign o_col    = w_col;
    assign o_ahead  = w_rtl ? (w_col - 1'b1) : (w_col + 1'b1);

    assign o_flags.above      = (w_row != '0);
    assign o_flags.behind     = (w_cnt != '0);
    assign o_flags.has_ahead  = ~w_row_last;
    assign o_flags.row_last   = w_row_last;
    assign o_flags.frame_last = w_frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_REG_W'(256);
            r_height  <= HEIGHT_REG_W'(256);
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (w_row_last) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= w_frame_last ? '0 : (w_row + 1'b1);
                end else begin
                    r_col_cnt <= w_cnt + 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/sedd_fifo.sv @@
`timescale 1ns / 1ps
// small first-word-fall-through queue between front and back end
// no dependencies

module sedd_fifo #(
    parameter int DW    = 32,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);

    logic [DW-1:0] r_data [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_data  = r_data[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : (r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : (r_rd_ptr + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/sedd_back.sv @@
`timescale 1ns / 1ps
// back end: previous-row error line store, four-term diffusion and clamp chain,
// threshold and output register; uses sedd_pkg

module sedd_back
    import sedd_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [AW-1:0]    i_col,
    input  logic [AW-1:0]    i_ahead,
    input  t_flags           i_flags,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_white,
    output logic             o_row_last,
    output logic             o_frame_last
);

    logic [ERR_W-1:0] r_mem [MAX_WIDTH];

    // execute stage
    logic                    r_b1_valid;
    logic [PIX_W-1:0]        r_b1_pixel;
    logic [AW-1:0]           r_b1_col;
    t_flags                  r_b1_flags;
    logic signed [ERR_W-1:0] r_rd_col;
    logic signed [ERR_W-1:0] r_rd_ahead;
    logic signed [ERR_W-1:0] r_held;
    logic signed [ERR_W-1:0] r_pred;

    // output register
    logic r_out_valid;
    logic r_out_white;
    logic r_out_row_last;
    logic r_out_frame_last;

    logic                    w_fire;
    logic [PIX_W-1:0]        w_v1;
    logic [PIX_W-1:0]        w_v2;
    logic [PIX_W-1:0]        w_v3;
    logic [PIX_W-1:0]        w_v4;
    logic                    w_white;
    logic signed [ERR_W-1:0] w_err;

    assign w_fire = r_b1_valid && (!r_out_valid || i_ready);
    assign o_pop  = i_avail && (!r_b1_valid || w_fire);

    always_comb begin
        w_v1 = (r_b1_flags.above && r_b1_flags.has_ahead)
             ? clamp_add(r_b1_pixel, diffuse(r_rd_ahead, K_AHEAD)) : r_b1_pixel;
        w_v2 = r_b1_flags.above ? clamp_add(w_v1, diffuse(r_rd_col, K_ABOVE)) : w_v1;
        w_v3 = (r_b1_flags.above && r_b1_flags.behind)
             ? clamp_add(w_v2, diffuse(r_held, K_BEHIND)) : w_v2;
        w_v4 = r_b1_flags.behind ? clamp_add(w_v3, diffuse(r_pred, K_PRED)) : w_v3;
        w_white = (w_v4 > THRESH);
        // wraps to value minus 255 in two's complement
        w_err = w_white ? $signed(w_v4 - PIX_MAX) : $signed(w_v4);
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_mem[r_b1_col] <= w_err;
        end
    end

    // registered reads; forward the error being written in the same cycle
    // (the first pixel of a row sits under the last pixel of the row before)
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_col   <= (w_fire && (r_b1_col == i_col)) ? w_err : $signed(r_mem[i_col]);
            r_rd_ahead <= (w_fire && (r_b1_col == i_ahead)) ? w_err
                                                            : $signed(r_mem[i_ahead]);
            r_b1_pixel <= i_pixel;
            r_b1_col   <= i_col;
            r_b1_flags <= i_flags;
        end
        if (w_fire) begin
            r_out_white      <= w_white;
            r_out_row_last   <= r_b1_flags.row_last;
            r_out_frame_last <= r_b1_flags.frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_pred      <= '0;
        end else begin
            if (o_pop) begin
                r_b1_valid <= 1'b1;
            end else if (w_fire) begin
                r_b1_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_held      <= r_rd_col;
                r_pred      <= w_err;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_white      = r_out_white;
    assign o_row_last   = r_out_row_last;
    assign o_frame_last = r_out_frame_last;

endmodule

@@ rtl/serpentine_error_diffusion_dither.sv @@
`timescale 1ns / 1ps
// top level of the serpentine error-diffusion dither: front end, queue, back end
// depends on sedd_pkg, sedd_front, sedd_fifo, sedd_back

// One 8-bit grey pixel in, one black/white pixel out, in serpentine order (row 0 right
// to left, then alternating). The block takes one pixel per clock when the output side
// keeps up; a beat passes the queue, the line store read register and output register.
// The rate is set by the single-port-write line store of the previous row's errors,
// which is read at two columns and written at one column per pixel. The store holds no
// reset contents and needs no clearing pass: every entry a frame reads was written
// earlier in that frame. Width and height must be written through the configuration
// channel (index 0 width, index 1 height) only while no pixel is in flight; the block
// does not enforce this. Zero acts as one and a value above the maximum as the maximum.

module serpentine_error_diffusion_dither
    import sedd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pixel_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [0] out_white, [7:1] zero
    output logic                  m_axis_tlast,   // row_last
    output logic                  m_axis_tuser    // [0] frame_last
);

    localparam int AW          = $clog2(MAX_WIDTH);
    localparam int QDEPTH      = 2;
    localparam int FLAG_W      = $bits(t_flags);
    localparam int DW          = PIX_W + 2 * AW + FLAG_W;

    logic             w_push;
    logic [PIX_W-1:0] w_f_pixel;
    logic [AW-1:0]    w_f_col;
    logic [AW-1:0]    w_f_ahead;
    t_flags           w_f_flags;
    logic [DW-1:0]    w_q_in;
    logic [DW-1:0]    w_q_out;
    logic             w_q_full;
    logic             w_q_empty;
    logic             w_pop;
    logic             w_white;
    logic [2:0]       r_inflight;

    assign o_cfg_ready = 1'b1;

    sedd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .i_pixel      (s_axis_tdata),
        .i_queue_full (w_q_full),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_pixel      (w_f_pixel),
        .o_col        (w_f_col),
        .o_ahead      (w_f_ahead),
        .o_flags      (w_f_flags)
    );

    assign w_q_in = {w_f_pixel, w_f_col, w_f_ahead, w_f_flags};

    sedd_fifo #(
        .DW    (DW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    sedd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (~w_q_empty),
        .i_pixel      (w_q_out[DW-1 -: PIX_W]),
        .i_col        (w_q_out[FLAG_W+AW +: AW]),
        .i_ahead      (w_q_out[FLAG_W +: AW]),
        .i_flags      (t_flags'(w_q_out[FLAG_W-1:0])),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_white      (w_white),
        .o_row_last   (m_axis_tlast),
        .o_frame_last (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, w_white};

    // pixels accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({s_axis_tvalid && s_axis_tready, m_axis_tvalid && m_axis_tready})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more pixels in flight than queue and stages hold");

    a_no_invented_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_inflight != 3'd0))
        else $error("output beat without an accepted pixel");

    a_frame_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame end not on a row end");

endmodule

@@ sim/serpentine_error_diffusion_dither_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for serpentine_error_diffusion_dither: pixel stream in, halftone beats out
// depends on sedd_pkg and the dither rtl; a local error-diffusion model predicts every beat

module serpentine_error_diffusion_dither_tb
    import sedd_pkg::*;
();

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 4096;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_PIX  = 760;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       user;
    } t_dither_beat;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    // model state
    int  cfg_width;
    int  cfg_height;
    int  line_err [MAX_W];
    int  pred_err;
    int  behind_err;
    int  cols_done;
    int  rows_done;
    bit  frame_closed;

    t_dither_beat halftone_q[$];

    int       fail_count;
    int       pixels_sent;
    int       frames_done;
    int       reg_writes;
    int       burst_left;
    int       quiet_cycles;
    t_rx_mode rx_mode;
    logic [5:0] rx_phase;

    serpentine_error_diffusion_dither #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- model

    function automatic int weighted_share(input int err, input int k);
        int n;
        n = err * k;
        if (n >= 0) return (n + 8) / 16;
        return -((-n + 8) / 16);
    endfunction

    function automatic int clip_grey(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic int eff_width();
        if (cfg_width < 1) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    task automatic diffuse_pixel(input logic [7:0] pix);
        int w, h, cnt, row, col, ahead, v, e;
        bit rtl, white, row_end, frame_end;
        w   = eff_width();
        h   = (cfg_height < 1) ? 1 : (cfg_height > MAX_H) ? MAX_H : cfg_height;
        cnt = (cols_done > w - 1) ? w - 1 : cols_done;
        row = (rows_done > h - 1) ? h - 1 : rows_done;
        rtl = (row % 2) == 0;
        col = rtl ? (w - 1 - cnt) : cnt;
        v   = pix;
        if (row > 0) begin
            if (cnt + 1 < w) begin
                ahead = rtl ? col - 1 : col + 1;
                v = clip_grey(v + weighted_share(line_err[ahead], 1));
            end
            v = clip_grey(v + weighted_share(line_err[col], 5));
            if (cnt > 0) v = clip_grey(v + weighted_share(behind_err, 3));
        end
        if (cnt > 0) v = clip_grey(v + weighted_share(pred_err, 7));
        white = v > 127;
        e     = white ? v - 255 : v;
        behind_err    = line_err[col];
        line_err[col] = e;
        pred_err      = e;
        row_end   = (cnt == w - 1);
        frame_end = row_end && (row == h - 1);
        if (row_end) begin
            cols_done  = 0;
            rows_done  = frame_end ? 0 : row + 1;
            pred_err   = 0;
            behind_err = 0;
        end else begin
            cols_done = cnt + 1;
        end
        halftone_q.push_back('{data: {7'd0, white}, last: row_end, user: frame_end});
        pixels_sent++;
        if (frame_end) frames_done++;
        frame_closed = frame_end;
    endtask

    // ---------------------------------------------------------------- drivers

    function automatic logic [7:0] grey_sample();
        case ($urandom_range(0, 9))
            0, 1:    return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            2:       return ($urandom_range(0, 1) != 0) ? 8'd128 : 8'd127;
            3, 4, 5: return 8'($urandom_range(100, 156));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input logic [7:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 24);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        diffuse_pixel(pix);
    endtask

    // drain the pipe, then write width and/or height while the block is idle
    task automatic reconfigure(input bit set_w, input int w_val, input bit set_h, input int h_val);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (halftone_q.size() != 0);
        if (set_w) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_IMAGE_WIDTH;
            i_cfg_data  <= CFG_DATA_W'(w_val);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            cfg_width = w_val & 'h7ff;
            reg_writes++;
        end
        if (set_h) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_IMAGE_HEIGHT;
            i_cfg_data  <= CFG_DATA_W'(h_val);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            cfg_height = h_val & 'h1fff;
            reg_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stalls, switching style each time the 6-bit phase counter reaches zero
    always @(posedge i_clk) begin
        if (rx_phase == 6'd0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        rx_phase <= rx_phase - 6'd1;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_axis_tready <= (rx_phase[2:0] != 3'd0);
            default:     m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        t_dither_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (halftone_q.size() == 0) begin
                $display("%0t: output beat with nothing pending: data=%h last=%b user=%b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                fail_count++;
            end else begin
                want = halftone_q.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $display("%0t: tdata expected %h actual %h", $time, want.data, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: tlast (row end) expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser !== want.user) begin
                    $display("%0t: tuser (frame end) expected %b actual %b",
                             $time, want.user, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- tests

    // a few pixels at the reset size, then shrink so the open row closes the frame
    task automatic test_reset_dims();
        push_pixel(8'd200);
        push_pixel(8'd60);
        push_pixel(8'd130);
        reconfigure(1, 4, 1, 1);
        push_pixel(8'd255);
    endtask

    // zero width and height act as one pixel per frame
    task automatic test_degenerate_dims();
        reconfigure(1, 0, 1, 0);
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd128);
    endtask

    // one column: only the straight-above term applies
    task automatic test_single_column();
        reconfigure(1, 1, 1, 3);
        push_pixel(8'd128);
        push_pixel(8'd127);
        push_pixel(8'd255);
    endtask

    // extreme pixels that drive the running value into both clamps
    task automatic test_clamp_corners();
        reconfigure(1, 3, 1, 3);
        push_pixel(8'd127);
        push_pixel(8'd255);
        push_pixel(8'd128);
        push_pixel(8'd0);
        push_pixel(8'd127);
        push_pixel(8'd255);
        push_pixel(8'd128);
        push_pixel(8'd0);
        push_pixel(8'd255);
    endtask

    // height above the maximum, then cut back mid-frame so the row saturates
    task automatic test_height_overflow();
        reconfigure(1, 2, 1, 8191);
        repeat (4) push_pixel(grey_sample());
        reconfigure(0, 0, 1, 1);
        repeat (2) push_pixel(grey_sample());
    endtask

    // full line store, out-of-range width alias, then a mid-row width shrink
    task automatic test_full_width();
        reconfigure(1, MAX_W, 1, 2);
        repeat (MAX_W + 20) push_pixel(grey_sample());
        reconfigure(1, 2047, 0, 0);
        repeat (10) push_pixel(grey_sample());
        reconfigure(1, 30, 0, 0);
        do push_pixel(grey_sample()); while (!frame_closed);
    endtask

    task automatic test_random_frames();
        int  start_count, w, h, cut_row;
        bit  tall, mid_done;
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIX) begin
            tall = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                7, 8:    w = $urandom_range(17, 64);
                9:       w = $urandom_range(65, 200);
                default: w = $urandom_range(3, 16);
            endcase
            if (tall) begin
                w       = $urandom_range(1, 4);
                h       = ($urandom_range(0, 1) != 0) ? MAX_H : $urandom_range(MAX_H + 1, 8191);
                cut_row = $urandom_range(1, 4);
            end else begin
                h       = $urandom_range(1, 6);
                cut_row = 0;
            end
            reconfigure(1, w, 1, h);
            mid_done = 0;
            do begin
                push_pixel(grey_sample());
                // mid-frame changes only past row 0, width never grows
                if (!frame_closed && rows_done > 0 && !mid_done) begin
                    if (cut_row != 0 && rows_done >= cut_row) begin
                        reconfigure(0, 0, 1, $urandom_range(0, rows_done));
                        mid_done = 1;
                    end else if (cut_row == 0 && $urandom_range(0, 59) == 0) begin
                        if ($urandom_range(0, 1) != 0)
                            reconfigure(1, $urandom_range(0, eff_width()), 0, 0);
                        else
                            reconfigure(0, 0, 1, $urandom_range(0, 8));
                        mid_done = 1;
                    end
                end
            end while (!frame_closed);
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        rx_mode       = RX_OPEN;
        rx_phase      = '0;
        quiet_cycles  = 0;
        fail_count    = 0;
        pixels_sent   = 0;
        frames_done   = 0;
        reg_writes    = 0;
        burst_left    = 0;
        cfg_width     = 256;
        cfg_height    = 256;
        pred_err      = 0;
        behind_err    = 0;
        cols_done     = 0;
        rows_done     = 0;
        frame_closed  = 0;
        foreach (line_err[i]) line_err[i] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_dims();
        test_degenerate_dims();
        test_single_column();
        test_clamp_corners();
        test_height_overflow();
        test_full_width();
        test_random_frames();

        s_axis_tvalid <= 1'b0;
        while (halftone_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("dithered %0d pixels over %0d frames with %0d register writes,",
                 pixels_sent, frames_done, reg_writes);
        $display("including full-width rows, degenerate sizes and mid-frame size cuts");
        if (fail_count == 0 && halftone_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
